// ===== src/utf8v_pkg.sv =====
// Package for the UTF-8 stream validator: byte-class masks, sequence
// lengths and the completed code point check. No dependencies.
package utf8v_pkg;

  // Sequence lengths held in the length register
  localparam logic [2:0] SeqLenNone = 3'd0;
  localparam logic [2:0] SeqLen2    = 3'd2;
  localparam logic [2:0] SeqLen3    = 3'd3;
  localparam logic [2:0] SeqLen4    = 3'd4;

  // Byte values and masks
  localparam logic [7:0] ByteDel     = 8'h7f;
  localparam logic [7:0] ByteTab     = 8'h09;
  localparam logic [7:0] ByteLf      = 8'h0a;
  localparam logic [7:0] ByteCr      = 8'h0d;
  localparam logic [7:0] CtrlLimit   = 8'h20;
  localparam logic [7:0] AsciiLimit  = 8'h80;
  localparam logic [7:0] Lead2Mask   = 8'he0;
  localparam logic [7:0] Lead2Match  = 8'hc0;
  localparam logic [7:0] Lead3Mask   = 8'hf0;
  localparam logic [7:0] Lead3Match  = 8'he0;
  localparam logic [7:0] Lead4Mask   = 8'hf8;
  localparam logic [7:0] Lead4Match  = 8'hf0;
  localparam logic [7:0] ContMask    = 8'hc0;
  localparam logic [7:0] ContMatch   = 8'h80;

  // Code point limits
  localparam logic [20:0] CpMin2     = 21'h000080;
  localparam logic [20:0] CpMin3     = 21'h000800;
  localparam logic [20:0] CpMin4     = 21'h010000;
  localparam logic [20:0] CpMax      = 21'h10ffff;
  localparam logic [20:0] SurrLow    = 21'h00d800;
  localparam logic [20:0] SurrHigh   = 21'h00dfff;

  // Flag an overlong, out-of-range or surrogate code point
  function automatic logic code_point_bad(logic [20:0] cp, logic [2:0] len);
    logic bad;
    bad = 1'b0;
    if (len == SeqLen2 && cp < CpMin2) bad = 1'b1;
    if (len == SeqLen3 && cp < CpMin3) bad = 1'b1;
    if (len == SeqLen4 && cp < CpMin4) bad = 1'b1;
    if (cp > CpMax) bad = 1'b1;
    if (cp inside {[SurrLow:SurrHigh]}) bad = 1'b1;
    return bad;
  endfunction

endpackage

// ===== src/utf8_stream_validator.sv =====
// Top level of the UTF-8 stream validator: decode state, sticky error and
// the result register. Depends on utf8v_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one byte of a string per
//   request, with end_of_string_i set on the final byte. Output channel
//   (out_valid_o / out_ready_i) returns one result per byte: still_valid_o
//   tells whether the string is clean so far, verdict_final_o marks the
//   result of the final byte, whose still_valid_o is the whole-string verdict.
//   A byte's result shows in the cycle after the byte is accepted.
//   Throughput is one byte per cycle while the receiver takes each result;
//   the decode of a byte is a single pass of shallow logic between the
//   decode state registers and the result register, so a new byte is taken
//   in the same cycle that the previous result is taken.
//   When the receiver stalls, the result register holds and in_ready_o drops
//   until the pending result is taken; nothing is lost.
//   Reset clears the decode state, the sticky error and the result valid
//   flag; the block is ready in the first cycle after reset. State clears
//   after every final byte, so the next byte opens a new string.
module utf8_stream_validator
  import utf8v_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       still_valid_o,
  output logic       verdict_final_o
);

  logic [1:0]  pend_q, pend_d;
  logic [20:0] cp_q, cp_d;
  logic [2:0]  len_q, len_d;
  logic        err_q, err_d;
  logic        out_valid_q, out_valid_d;
  logic        still_valid_q, still_valid_d;
  logic        verdict_final_q, verdict_final_d;
  logic        in_accept;
  logic        forbidden;
  logic [20:0] cp_ext;

  // Accept while the result register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign forbidden = (data_byte_i == ByteDel) ||
                     ((data_byte_i < CtrlLimit) && (data_byte_i != ByteTab) &&
                      (data_byte_i != ByteLf) && (data_byte_i != ByteCr));
  assign cp_ext = {cp_q[14:0], data_byte_i[5:0]};

  // Decode one byte against the current state
  always_comb begin
    pend_d = pend_q;
    cp_d   = cp_q;
    len_d  = len_q;
    err_d  = err_q;
    if (!err_q) begin
      if (pend_q == 2'd0) begin
        // lead position
        if (forbidden) begin
          err_d = 1'b1;
        end else if (data_byte_i < AsciiLimit) begin
          err_d = 1'b0;
        end else if ((data_byte_i & Lead2Mask) == Lead2Match) begin
          len_d  = SeqLen2;
          cp_d   = {16'd0, data_byte_i[4:0]};
          pend_d = 2'd1;
        end else if ((data_byte_i & Lead3Mask) == Lead3Match) begin
          len_d  = SeqLen3;
          cp_d   = {17'd0, data_byte_i[3:0]};
          pend_d = 2'd2;
        end else if ((data_byte_i & Lead4Mask) == Lead4Match) begin
          len_d  = SeqLen4;
          cp_d   = {18'd0, data_byte_i[2:0]};
          pend_d = 2'd3;
        end else begin
          err_d = 1'b1;
        end
      end else begin
        // continuation position
        if ((data_byte_i & ContMask) != ContMatch) begin
          err_d = 1'b1;
        end else if (pend_q == 2'd1) begin
          if (code_point_bad(cp_ext, len_q)) err_d = 1'b1;
          cp_d   = 21'd0;
          len_d  = SeqLenNone;
          pend_d = 2'd0;
        end else begin
          cp_d   = cp_ext;
          pend_d = pend_q - 2'd1;
        end
      end
    end
    // truncated sequence at the final byte
    if (end_of_string_i && !err_d && (pend_d != 2'd0)) err_d = 1'b1;
    // drop the open sequence on error
    if (err_d) begin
      cp_d   = 21'd0;
      len_d  = SeqLenNone;
      pend_d = 2'd0;
    end
    still_valid_d   = !err_d;
    verdict_final_d = end_of_string_i;
    // clear everything after the final byte
    if (end_of_string_i) begin
      cp_d   = 21'd0;
      len_d  = SeqLenNone;
      pend_d = 2'd0;
      err_d  = 1'b0;
    end
  end

  // Result valid: set on accept, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Advance the control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 2'd0;
      cp_q        <= 21'd0;
      len_q       <= SeqLenNone;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        pend_q <= pend_d;
        cp_q   <= cp_d;
        len_q  <= len_d;
        err_q  <= err_d;
      end
    end
  end

  // Hold the result payload until the next accepted request
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      still_valid_q   <= still_valid_d;
      verdict_final_q <= verdict_final_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign still_valid_o   = still_valid_q;
  assign verdict_final_o = verdict_final_q;

endmodule

// ===== src/utf8v_checker.sv =====
// Port-level checks for the UTF-8 stream validator, bound to its top level.
// Depends only on the top level's ports.
module utf8v_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       end_of_string_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       still_valid_o,
  input logic       verdict_final_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(still_valid_o) &&
    $stable(verdict_final_o))
    else $error("stalled result changed");

  // Every accepted request shows a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("result missing after accepted request");

  // The final byte closes the string in its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> (verdict_final_o == $past(end_of_string_i)))
    else $error("verdict_final does not follow end_of_string");

  // A NUL byte can never leave a string valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (data_byte_i == 8'h00) |=> !still_valid_o)
    else $error("NUL byte passed as valid");

  // Back-pressure only while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .data_byte_i     (data_byte_i),
  .end_of_string_i (end_of_string_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .still_valid_o   (still_valid_o),
  .verdict_final_o (verdict_final_o)
);
